@@ hw/rtl/seven_segment_two_wire_writer_assert.svh @@
`ifndef SEVEN_SEGMENT_TWO_WIRE_WRITER_ASSERT_SVH
`define SEVEN_SEGMENT_TWO_WIRE_WRITER_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define SSW_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSW_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/sstw_pkg.sv @@
package sstw_pkg;

	// display geometry and pattern table
	localparam int DIGIT_COUNT = 4;
	localparam int TABLE_DEPTH = 128;
	localparam int TBL_AW      = $clog2(TABLE_DEPTH);
	localparam int DIG_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam int SEG_W       = $clog2(DIGIT_COUNT + 2);

	// field widths
	localparam int OP_W        = 3;
	localparam int NUM_W       = 14;
	localparam int CODE_W      = 8;
	localparam int POS_W       = 2;
	localparam int IDX_W       = 7;
	localparam int IN_DATA_W   = 72;
	localparam int OUT_DATA_W  = 8;

	// input word layout (after op, which rides in tuser)
	localparam int NUM_LSB     = 0;
	localparam int CODE0_LSB   = 14;
	localparam int POS_LSB     = 46;
	localparam int DCODE_LSB   = 48;
	localparam int TIDX_LSB    = 56;
	localparam int TVAL_LSB    = 63;

	// configuration port
	localparam int APB_AW      = 4;
	localparam int APB_DW      = 32;
	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_ADDR = 2'd1;
	localparam logic [1:0] REG_CTRL = 2'd2;
	localparam logic [7:0] MODE_RST = 8'd64;
	localparam logic [7:0] ADDR_RST = 8'd192;
	localparam logic [7:0] CTRL_RST = 8'd143;

	localparam logic [7:0] BLANK_CODE = 8'd10;
	localparam logic [7:0] DOT_BIT    = 8'h80;

	// largest value the digits can show, capped at four digits
	function automatic int num_limit(input int digits);
		int lim;
		lim = 1;
		for (int i = 0; i < digits; i++) begin
			if (lim <= 9999) begin
				lim = lim * 10;
			end
		end
		lim = lim - 1;
		if (lim > 9999) begin
			lim = 9999;
		end
		return lim;
	endfunction

	localparam int BCD_W = 4 * DIGIT_COUNT;
	localparam logic [NUM_W-1:0] NUM_LIMIT = NUM_W'(num_limit(DIGIT_COUNT));
	localparam int CNT_W = $clog2(NUM_W + 1);

	typedef enum logic [OP_W-1:0] {
		OP_TICK   = 3'd0,
		OP_NUMBER = 3'd1,
		OP_CODES  = 3'd2,
		OP_DIGIT  = 3'd3,
		OP_LOAD   = 3'd4
	} op_t;

	// power-up contents of the pattern table
	function automatic logic [7:0] seg_default(input logic [TBL_AW-1:0] idx);
		logic [7:0] pat;
		case (idx)
			TBL_AW'(0): pat = 8'h3F;
			TBL_AW'(1): pat = 8'h06;
			TBL_AW'(2): pat = 8'h5B;
			TBL_AW'(3): pat = 8'h4F;
			TBL_AW'(4): pat = 8'h66;
			TBL_AW'(5): pat = 8'h6D;
			TBL_AW'(6): pat = 8'h7D;
			TBL_AW'(7): pat = 8'h07;
			TBL_AW'(8): pat = 8'h7F;
			TBL_AW'(9): pat = 8'h6F;
			default:    pat = 8'h00;
		endcase
		return pat;
	endfunction

endpackage

@@ hw/rtl/seven_segment_two_wire_writer.sv @@
// Each accepted input word yields one registered result word; one word per cycle sustained while m_tready stays high.
// Each tick word accepted while busy advances the link by one pin phase, 316 ticks per full frame.
// A number command is turned into decimal by a shift-add unit that runs behind the frame.
// Pattern table: 128 x 8 synchronous memory, one read port, per-entry valid flops.
// Reset (arst_n low, asynchronous): pins high, idle, registers to defaults, table at digit shapes.
module seven_segment_two_wire_writer (
	input  logic                              clk,
	input  logic                              arst_n,
	// slave side
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// number, code0, code1, code2, code3, digit_position, digit_code, table_index, table_value
	input  logic [sstw_pkg::IN_DATA_W-1:0]    s_tdata,
	// op
	input  logic [sstw_pkg::OP_W-1:0]         s_tuser,
	// master side
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// clk_level, dio_level, busy_res
	output logic [sstw_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tlast,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [sstw_pkg::APB_AW-1:0]       paddr,
	input  logic [sstw_pkg::APB_DW-1:0]       pwdata,
	output logic [sstw_pkg::APB_DW-1:0]       prdata,
	output logic                              pready
);
	import sstw_pkg::*;

	typedef enum logic [1:0] {
		P_START,
		P_BIT,
		P_ACK,
		P_STOP
	} part_t;

	// configuration registers
	logic [7:0] mode_q, addr_base_q, ctrl_q;

	// frame state
	logic                busy_q, clk_q, dio_q;
	logic                frame_kind_q, num_mode_q;
	logic [POS_W-1:0]    single_pos_q;
	logic [CODE_W-1:0]   code_q [DIGIT_COUNT];
	part_t               part_q;
	logic [1:0]          ph_q;
	logic [2:0]          bit_q;
	logic                bsel_q;
	logic [SEG_W-1:0]    seg_q;

	// decimal conversion
	logic [BCD_W-1:0]    bcd_q, bcd_adj;
	logic [NUM_W-1:0]    bin_q;
	logic [CNT_W-1:0]    conv_cnt_q;

	// pattern table
	logic [7:0]          tbl_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] tbl_vld_q;
	logic [7:0]          tbl_rd_s1;
	logic                tbl_vld_s1, tbl_hit_s1;
	logic [TBL_AW-1:0]   tbl_addr_s1;

	// output stage
	logic                out_vld_q, skid_vld_q;
	logic [2:0]          out_q, skid_q;
	logic                out_last_q, skid_last_q;

	// combinational
	op_t                 op;
	logic                acc, cfg_we, tick_go, cmd_go, tbl_we, pop;
	logic [NUM_W-1:0]    num_sat;
	logic [CODE_W-1:0]   num_code [DIGIT_COUNT];
	logic [DIG_W-1:0]    dig_idx;
	logic [CODE_W-1:0]   cur_code;
	logic [TBL_AW-1:0]   rd_addr;
	logic                rd_hit;
	logic [TBL_AW-1:0]   ld_addr;
	logic [7:0]          pattern, cur_byte, pos_byte;
	logic [SEG_W-1:0]    last_seg;
	logic                clk_n, dio_n, busy_n, done_c;
	part_t               part_n;
	logic [1:0]          ph_n;
	logic [2:0]          bit_n;
	logic                bsel_n;
	logic [SEG_W-1:0]    seg_n;

	// handshake
	assign s_tready = !skid_vld_q;
	assign acc      = s_tvalid && s_tready;
	assign op       = op_t'(s_tuser);
	assign tick_go  = acc && (op == OP_TICK) && busy_q;
	assign cmd_go   = acc && !busy_q &&
		((op == OP_NUMBER) || (op == OP_CODES) || (op == OP_DIGIT));
	assign ld_addr  = TBL_AW'(s_tdata[TIDX_LSB +: IDX_W]);
	assign tbl_we   = acc && !busy_q && (op == OP_LOAD) &&
		(32'(s_tdata[TIDX_LSB +: IDX_W]) < TABLE_DEPTH);

	// apb port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[3:2])
			REG_MODE: prdata = APB_DW'(mode_q);
			REG_ADDR: prdata = APB_DW'(addr_base_q);
			REG_CTRL: prdata = APB_DW'(ctrl_q);
			default:  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_RST;
			addr_base_q <= ADDR_RST;
			ctrl_q      <= CTRL_RST;
		end else if (cfg_we) begin
			case (paddr[3:2])
				REG_MODE: mode_q      <= pwdata[7:0];
				REG_ADDR: addr_base_q <= pwdata[7:0];
				REG_CTRL: ctrl_q      <= pwdata[7:0];
				default:  ;
			endcase
		end
	end

	// saturate the incoming number
	assign num_sat = (s_tdata[NUM_LSB +: NUM_W] > NUM_LIMIT) ? NUM_LIMIT :
		s_tdata[NUM_LSB +: NUM_W];

	// shift-add-3 correction of each decimal digit
	always_comb begin
		bcd_adj = bcd_q;
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end
		end
	end

	// decimal digits to codes, leading zeros blanked but never the units digit
	always_comb begin
		logic lead;
		logic [3:0] dv;
		lead = 1'b1;
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			dv = bcd_q[(DIGIT_COUNT-1-i)*4 +: 4];
			if (lead && (dv == 4'd0) && (i < DIGIT_COUNT - 1)) begin
				num_code[i] = BLANK_CODE;
			end else begin
				lead = 1'b0;
				num_code[i] = CODE_W'(dv);
			end
		end
	end

	// code of the digit segment in progress
	always_comb begin
		if (frame_kind_q || (seg_q == '0)) begin
			dig_idx = '0;
		end else begin
			dig_idx = DIG_W'(seg_q - SEG_W'(1));
		end
		cur_code = num_mode_q ? num_code[dig_idx] : code_q[dig_idx];
		rd_addr  = TBL_AW'(cur_code[IDX_W-1:0]);
		rd_hit   = (32'(cur_code[IDX_W-1:0]) < TABLE_DEPTH);
	end

	// pattern table: loads only while idle, reads only matter while busy, and the
	// first pattern byte is 65 ticks into a frame, so read data is always fresh
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[ld_addr] <= s_tdata[TVAL_LSB +: 8];
		end
		tbl_rd_s1   <= tbl_mem[rd_addr];
		tbl_vld_s1  <= tbl_vld_q[rd_addr];
		tbl_hit_s1  <= rd_hit;
		tbl_addr_s1 <= rd_addr;
	end

	// entries never loaded read as their power-up shapes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_vld_q <= '0;
		end else if (tbl_we) begin
			tbl_vld_q[ld_addr] <= 1'b1;
		end
	end

	// byte being sent
	always_comb begin
		pattern  = (tbl_hit_s1 ? (tbl_vld_s1 ? tbl_rd_s1 : seg_default(tbl_addr_s1)) : 8'h00)
			| (cur_code & DOT_BIT);
		pos_byte = frame_kind_q ? 8'(single_pos_q) : (8'(seg_q) - 8'd1);
		last_seg = frame_kind_q ? SEG_W'(2) : SEG_W'(DIGIT_COUNT + 1);
		if (seg_q == '0) begin
			cur_byte = mode_q;
		end else if (seg_q == last_seg) begin
			cur_byte = ctrl_q;
		end else if (bsel_q) begin
			cur_byte = pattern;
		end else begin
			cur_byte = addr_base_q + pos_byte;
		end
	end

	// phase sequencer: start, bits with ack, stop
	always_comb begin
		clk_n  = clk_q;
		dio_n  = dio_q;
		busy_n = busy_q;
		done_c = 1'b0;
		part_n = part_q;
		ph_n   = ph_q;
		bit_n  = bit_q;
		bsel_n = bsel_q;
		seg_n  = seg_q;
		if (tick_go) begin
			case (part_q)
				P_START: begin
					if (ph_q == 2'd0) begin
						clk_n = 1'b1;
					end else if (ph_q == 2'd1) begin
						dio_n = 1'b1;
					end else begin
						dio_n = 1'b0;
					end
					if (ph_q == 2'd2) begin
						part_n = P_BIT;
						ph_n   = 2'd0;
						bit_n  = 3'd0;
					end else begin
						ph_n = ph_q + 2'd1;
					end
				end
				P_BIT: begin
					if (ph_q == 2'd0) begin
						clk_n = 1'b0;
					end else if (ph_q == 2'd1) begin
						dio_n = cur_byte[bit_q];
					end else begin
						clk_n = 1'b1;
					end
					if (ph_q == 2'd2) begin
						ph_n = 2'd0;
						if (bit_q == 3'd7) begin
							part_n = P_ACK;
						end else begin
							bit_n = bit_q + 3'd1;
						end
					end else begin
						ph_n = ph_q + 2'd1;
					end
				end
				P_ACK: begin
					if (ph_q == 2'd2) begin
						dio_n = 1'b0;
					end else begin
						clk_n = (ph_q == 2'd1);
					end
					ph_n = ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						ph_n = 2'd0;
						if ((seg_q != '0) && (seg_q != last_seg) && !bsel_q) begin
							part_n = P_BIT;
							bsel_n = 1'b1;
							bit_n  = 3'd0;
						end else begin
							part_n = P_STOP;
						end
					end
				end
				P_STOP: begin
					if (ph_q == 2'd1) begin
						clk_n = 1'b1;
					end else begin
						dio_n = (ph_q == 2'd2);
					end
					if (ph_q == 2'd2) begin
						part_n = P_START;
						ph_n   = 2'd0;
						bsel_n = 1'b0;
						if (seg_q == last_seg) begin
							seg_n  = '0;
							busy_n = 1'b0;
							done_c = 1'b1;
						end else begin
							seg_n = seg_q + SEG_W'(1);
						end
					end else begin
						ph_n = ph_q + 2'd1;
					end
				end
				default: begin
					part_n = P_START;
				end
			endcase
		end else if (cmd_go) begin
			busy_n = 1'b1;
		end
	end

	// frame state and command latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			clk_q        <= 1'b1;
			dio_q        <= 1'b1;
			part_q       <= P_START;
			ph_q         <= 2'd0;
			bit_q        <= 3'd0;
			bsel_q       <= 1'b0;
			seg_q        <= '0;
			frame_kind_q <= 1'b0;
			num_mode_q   <= 1'b0;
			single_pos_q <= '0;
			conv_cnt_q   <= '0;
		end else begin
			busy_q <= busy_n;
			clk_q  <= clk_n;
			dio_q  <= dio_n;
			part_q <= part_n;
			ph_q   <= ph_n;
			bit_q  <= bit_n;
			bsel_q <= bsel_n;
			seg_q  <= seg_n;
			if (cmd_go) begin
				case (op)
					OP_NUMBER: begin
						frame_kind_q <= 1'b0;
						num_mode_q   <= 1'b1;
						conv_cnt_q   <= CNT_W'(NUM_W);
					end
					OP_CODES: begin
						frame_kind_q <= 1'b0;
						num_mode_q   <= 1'b0;
					end
					OP_DIGIT: begin
						frame_kind_q <= 1'b1;
						num_mode_q   <= 1'b0;
						single_pos_q <= s_tdata[POS_LSB +: POS_W];
					end
					default: ;
				endcase
			end else if (conv_cnt_q != '0) begin
				conv_cnt_q <= conv_cnt_q - CNT_W'(1);
			end
		end
	end

	// payload: codes and the conversion shift register
	always_ff @(posedge clk) begin
		if (cmd_go && (op == OP_NUMBER)) begin
			bin_q <= num_sat;
			bcd_q <= '0;
		end else if (conv_cnt_q != '0) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[NUM_W-1]};
			bin_q <= {bin_q[NUM_W-2:0], 1'b0};
		end
		if (cmd_go && (op == OP_CODES)) begin
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				code_q[i] <= (i < 4) ? s_tdata[CODE0_LSB + 8*(i % 4) +: CODE_W] : BLANK_CODE;
			end
		end else if (cmd_go && (op == OP_DIGIT)) begin
			code_q[0] <= s_tdata[DCODE_LSB +: CODE_W];
		end
	end

	// output register with a skid entry behind it
	assign pop = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pop) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= acc;
			end
		end else if (acc) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_vld_q) begin
				out_q      <= skid_q;
				out_last_q <= skid_last_q;
			end else if (acc) begin
				out_q      <= {busy_n, dio_n, clk_n};
				out_last_q <= done_c;
			end
		end else if (acc) begin
			skid_q      <= {busy_n, dio_n, clk_n};
			skid_last_q <= done_c;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_DATA_W'(out_q);
	assign m_tlast  = out_last_q;

	`include "seven_segment_two_wire_writer_assert.svh"

	// skid entry only fills behind a held result
	`SSW_ASSERT_IMPL(a_skid_behind_out, skid_vld_q, out_vld_q, "skid word without output word")
	// frame end drops busy
	`SSW_ASSERT_NEXT(a_done_clears_busy, done_c && tick_go, !busy_q, "busy held after frame end")
	// decimal conversion is over before the first digit segment
	`SSW_ASSERT_IMPL(a_conv_early, conv_cnt_q != '0, seg_q == '0, "conversion still running")
	// sequencer rests at frame start while idle
	`SSW_ASSERT_IMPL(a_idle_rest, !busy_q,
		(seg_q == '0) && (part_q == P_START) && (ph_q == 2'd0) && !bsel_q,
		"sequencer not at rest while idle")
	// a latched command starts a frame
	`SSW_ASSERT_NEXT(a_cmd_starts, cmd_go, busy_q, "command did not start a frame")

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import sstw_pkg::*;

	// frame geometry in pin phases
	localparam int SHORT_LEN   = 34;
	localparam int DIGIT_LEN   = 62;
	localparam int NUMBER_MAX  = 9999;
	localparam int IDLE_PCT    = 38;
	// word budget for the random frames, the directed frames come on top
	localparam int RANDOM_WORDS = 160;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_CAP   = 40;
	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic clk_level;
		logic dio_level;
		logic busy;
		logic done;
	} pins_t;

	// display link predictor and queue of expected pin words
	class link_scoreboard;
		logic [7:0]  seg_table [TABLE_DEPTH];
		logic [7:0]  frame_pat [DIGIT_COUNT];
		logic        single_kind;
		logic [1:0]  single_pos;
		int unsigned step;
		logic [7:0]  shift_reg;
		logic        clk_pin;
		logic        dio_pin;
		logic        busy;
		logic [7:0]  mode_cmd;
		logic [7:0]  addr_base;
		logic [7:0]  disp_ctrl;
		pins_t       expected_pins [$];
		int unsigned errors;

		function new();
			foreach (seg_table[i]) seg_table[i] = 8'h00;
			seg_table[0] = 8'h3F;
			seg_table[1] = 8'h06;
			seg_table[2] = 8'h5B;
			seg_table[3] = 8'h4F;
			seg_table[4] = 8'h66;
			seg_table[5] = 8'h6D;
			seg_table[6] = 8'h7D;
			seg_table[7] = 8'h07;
			seg_table[8] = 8'h7F;
			seg_table[9] = 8'h6F;
			foreach (frame_pat[i]) frame_pat[i] = 8'h00;
			single_kind = 1'b0;
			single_pos  = 2'd0;
			step        = 0;
			shift_reg   = 8'h00;
			clk_pin     = 1'b1;
			dio_pin     = 1'b1;
			busy        = 1'b0;
			mode_cmd    = MODE_RST;
			addr_base   = ADDR_RST;
			disp_ctrl   = CTRL_RST;
			errors      = 0;
		endfunction

		function bit is_busy();
			return busy;
		endfunction

		function int pending();
			return expected_pins.size();
		endfunction

		function void set_reg(logic [1:0] idx, logic [7:0] val);
			case (idx)
				REG_MODE: mode_cmd = val;
				REG_ADDR: addr_base = val;
				REG_CTRL: disp_ctrl = val;
				default: ;
			endcase
		endfunction

		function logic [7:0] pattern_of(logic [7:0] code);
			return seg_table[code[6:0]] | (code & DOT_BIT);
		endfunction

		// one phase of a byte: three per bit, four for the acknowledge
		function void byte_phase(int unsigned p);
			if (p < 24) begin
				case (p % 3)
					0: clk_pin = 1'b0;
					1: dio_pin = shift_reg[p / 3];
					default: clk_pin = 1'b1;
				endcase
			end else if (p == 24) begin
				clk_pin = 1'b0;
			end else if (p == 25) begin
				clk_pin = 1'b1;
			end else if (p == 26) begin
				dio_pin = 1'b0;
			end else begin
				clk_pin = 1'b0;
			end
		endfunction

		// start, bytes, stop
		function void segment_phase(int unsigned l, int unsigned nbytes,
			logic [7:0] b0, logic [7:0] b1);
			int unsigned q;
			if (l < 3) begin
				if (l == 0) clk_pin = 1'b1;
				else if (l == 1) dio_pin = 1'b1;
				else dio_pin = 1'b0;
			end else if (l < 3 + 28 * nbytes) begin
				shift_reg = ((l - 3) / 28 == 0) ? b0 : b1;
				byte_phase((l - 3) % 28);
			end else begin
				q = l - 3 - 28 * nbytes;
				if (q == 0) dio_pin = 1'b0;
				else if (q == 1) clk_pin = 1'b1;
				else dio_pin = 1'b1;
			end
		endfunction

		// applies the current phase, returns 1 on the last one of the frame
		function bit apply_phase();
			int unsigned s;
			int unsigned ndig;
			int unsigned d;
			int unsigned pos;
			s = step;
			ndig = single_kind ? 1 : DIGIT_COUNT;
			if (s < SHORT_LEN) begin
				segment_phase(s, 1, mode_cmd, 8'h00);
				return 1'b0;
			end
			s = s - SHORT_LEN;
			if (s < DIGIT_LEN * ndig) begin
				d = s / DIGIT_LEN;
				pos = single_kind ? 32'(single_pos) : d;
				segment_phase(s % DIGIT_LEN, 2, addr_base + 8'(pos),
					frame_pat[single_kind ? 0 : d]);
				return 1'b0;
			end
			s = s - DIGIT_LEN * ndig;
			segment_phase(s, 1, disp_ctrl, 8'h00);
			return (s + 1 >= SHORT_LEN);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= PRINT_CAP) $display("%0t ns: %s", $time, msg);
		endtask

		// accepted input word: advance the prediction
		task note_word(logic [OP_W-1:0] op, logic [IN_DATA_W-1:0] data);
			int unsigned n;
			int          i;
			logic [7:0]  c;
			logic [3:0]  dg [DIGIT_COUNT];
			bit          lead;
			logic        done;
			pins_t       want;
			done = 1'b0;
			if (op == OP_TICK) begin
				if (busy) begin
					if (apply_phase()) begin
						busy = 1'b0;
						step = 0;
						done = 1'b1;
					end else begin
						step++;
					end
				end
			end else if (!busy && op == OP_NUMBER) begin
				n = 32'(data[NUM_LSB +: NUM_W]);
				if (n > NUMBER_MAX) n = NUMBER_MAX;
				for (i = DIGIT_COUNT - 1; i >= 0; i--) begin
					dg[i] = 4'(n % 10);
					n = n / 10;
				end
				// leading zeros blank, the last digit always shows
				lead = 1'b1;
				for (i = 0; i < DIGIT_COUNT; i++) begin
					c = 8'(dg[i]);
					if (lead && c == 8'd0 && i + 1 < DIGIT_COUNT) c = BLANK_CODE;
					else lead = 1'b0;
					frame_pat[i] = pattern_of(c);
				end
				single_kind = 1'b0;
				step = 0;
				busy = 1'b1;
			end else if (!busy && op == OP_CODES) begin
				for (i = 0; i < DIGIT_COUNT; i++) begin
					c = (i < 4) ? data[CODE0_LSB + CODE_W * i +: CODE_W] : BLANK_CODE;
					frame_pat[i] = pattern_of(c);
				end
				single_kind = 1'b0;
				step = 0;
				busy = 1'b1;
			end else if (!busy && op == OP_DIGIT) begin
				single_pos = data[POS_LSB +: POS_W];
				frame_pat[0] = pattern_of(data[DCODE_LSB +: CODE_W]);
				single_kind = 1'b1;
				step = 0;
				busy = 1'b1;
			end else if (!busy && op == OP_LOAD) begin
				seg_table[data[TIDX_LSB +: IDX_W]] = data[TVAL_LSB +: 8];
			end
			want = {clk_pin, dio_pin, busy, done};
			expected_pins.push_back(want);
		endtask

		// accepted output word against the oldest expectation
		task check_word(logic [OUT_DATA_W-1:0] tdata, logic tlast);
			pins_t want;
			if (expected_pins.size() == 0) begin
				report($sformatf("unexpected word %h last %b", tdata, tlast));
				return;
			end
			want = expected_pins.pop_front();
			if (tdata[0] !== want.clk_level)
				report($sformatf("clk_level got %b want %b", tdata[0], want.clk_level));
			if (tdata[1] !== want.dio_level)
				report($sformatf("dio_level got %b want %b", tdata[1], want.dio_level));
			if (tdata[2] !== want.busy)
				report($sformatf("busy got %b want %b", tdata[2], want.busy));
			if (tdata[7:3] !== 5'd0)
				report($sformatf("pad bits got %b", tdata[7:3]));
			if (tlast !== want.done)
				report($sformatf("frame_done got %b want %b", tlast, want.done));
		endtask
	endclass

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic [OP_W-1:0]       s_tuser  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_AW-1:0]     paddr    = '0;
	logic [APB_DW-1:0]     pwdata   = '0;
	logic [APB_DW-1:0]     prdata;
	logic                  pready;

	bit          calm = 1'b0;
	int unsigned cycles = 0;
	int unsigned words_sent = 0;
	link_scoreboard sb;

	seven_segment_two_wire_writer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #1 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result side: check accepted words, stall at random unless calm is set
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast);
		m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	function automatic logic [IN_DATA_W-1:0] word_of(int unsigned num, logic [7:0] c0,
		logic [7:0] c1, logic [7:0] c2, logic [7:0] c3, logic [1:0] pos,
		logic [7:0] dcode, logic [6:0] tidx, logic [7:0] tval);
		logic [IN_DATA_W-1:0] w;
		w = '0;
		w[NUM_LSB +: NUM_W] = NUM_W'(num);
		w[CODE0_LSB +: CODE_W] = c0;
		w[CODE0_LSB + CODE_W +: CODE_W] = c1;
		w[CODE0_LSB + 2 * CODE_W +: CODE_W] = c2;
		w[CODE0_LSB + 3 * CODE_W +: CODE_W] = c3;
		w[POS_LSB +: POS_W] = pos;
		w[DCODE_LSB +: CODE_W] = dcode;
		w[TIDX_LSB +: IDX_W] = tidx;
		w[TVAL_LSB +: 8] = tval;
		return w;
	endfunction

	// number command word, other fields zero
	function automatic logic [IN_DATA_W-1:0] num_word(input int unsigned num);
		return word_of(num, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0, 8'h00, 7'd0, 8'h00);
	endfunction

	// table load word, other fields zero
	function automatic logic [IN_DATA_W-1:0] load_word(input logic [6:0] tidx,
		input logic [7:0] tval);
		return word_of(0, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0, 8'h00, tidx, tval);
	endfunction

	// codes lean toward the digit and blank entries of the table
	function automatic logic [7:0] random_code();
		if ($urandom_range(1)) return 8'($urandom_range(255));
		return ($urandom_range(1) ? DOT_BIT : 8'h00) | 8'($urandom_range(10));
	endfunction

	function automatic int unsigned random_number();
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0) return $urandom_range((1 << NUM_W) - 1);
		if (r < 3) return $urandom_range(99);
		return $urandom_range(NUMBER_MAX);
	endfunction

	function automatic logic [IN_DATA_W-1:0] random_word();
		logic [6:0] tidx;
		tidx = $urandom_range(1) ? 7'($urandom_range(10)) : 7'($urandom_range(127));
		return word_of(random_number(), random_code(), random_code(), random_code(),
			random_code(), 2'($urandom_range(3)), random_code(), tidx,
			8'($urandom_range(255)));
	endfunction

	function automatic logic [OP_W-1:0] random_command();
		int unsigned r;
		r = $urandom_range(9);
		if (r < 3) return OP_NUMBER;
		if (r < 6) return OP_CODES;
		return OP_DIGIT;
	endfunction

	// one input word, with random idle cycles ahead of it unless calm is set
	task automatic send(input logic [OP_W-1:0] op, input logic [IN_DATA_W-1:0] data);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		sb.note_word(op, data);
		words_sent++;
	endtask

	task automatic finish_frame();
		while (sb.is_busy()) send(OP_TICK, random_word());
	endtask

	// idle link and nothing outstanding
	task automatic settle();
		finish_frame();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write, then read back
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		logic [APB_DW-1:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'({idx, 2'b00});
		pwdata  <= APB_DW'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, val);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		psel    <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got !== APB_DW'(val))
			sb.report($sformatf("register %0d read %h want %h", idx, got, val));
	endtask

	task automatic set_config(input logic [7:0] mode, input logic [7:0] abase,
		input logic [7:0] ctrl);
		write_reg(REG_MODE, mode);
		write_reg(REG_ADDR, abase);
		write_reg(REG_CTRL, ctrl);
	endtask

	// mostly complete frames with random content, some noise in between
	task automatic random_phase(input int unsigned count);
		int unsigned start;
		start = words_sent;
		while (words_sent - start < count) begin
			if ($urandom_range(99) < 75) begin
				finish_frame();
				repeat ($urandom_range(2)) send(OP_LOAD, random_word());
				send(random_command(), random_word());
				while (sb.is_busy()) begin
					if ($urandom_range(99) < 4) send(3'($urandom_range(7)), random_word());
					else send(OP_TICK, random_word());
				end
			end else begin
				repeat ($urandom_range(1, 6)) send(3'($urandom_range(7)), random_word());
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle tick and unused ops leave the pins alone
		send(OP_TICK, random_word());
		send(OP_SPARE_FIRST, random_word());
		send(OP_SPARE_LAST, random_word());
		// saturation, with commands and table loads dropped during the frame
		send(OP_NUMBER, num_word((1 << NUM_W) - 1));
		repeat (5) send(OP_TICK, random_word());
		send(OP_NUMBER, num_word(1234));
		send(OP_LOAD, load_word(7'd1, 8'hFF));
		send(OP_CODES, random_word());
		send(OP_DIGIT, random_word());
		finish_frame();
		// leading blank and inner zero, with the blank entry loaded
		send(OP_LOAD, load_word(7'd10, 8'h40));
		send(OP_NUMBER, num_word(105));
		finish_frame();
		// codes with and without dot
		send(OP_LOAD, load_word(7'd127, 8'hFF));
		send(OP_CODES, word_of(0, 8'h00, 8'h7F, 8'h8A, 8'hFF, 2'd0, 8'h00, 7'd0, 8'h00));
		finish_frame();
		// single digit at the far end
		send(OP_LOAD, load_word(7'd10, 8'h00));
		send(OP_DIGIT, word_of(0, 8'h00, 8'h00, 8'h00, 8'h00, 2'd3, 8'h80, 7'd0, 8'h00));
		settle();

		// random frames: no idling first, then random registers with stalls
		calm = 1'b1;
		set_config(8'hFF, 8'hFF, 8'hFF);
		random_phase(RANDOM_WORDS / 2);
		settle();
		calm = 1'b0;
		set_config(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
		random_phase(RANDOM_WORDS / 2);

		// drain
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
